// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros used by the detector's result engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property check failed");

// Condition that must never be true on a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== hw/rtl/drod_pkg.sv =====
// Shared types and constants of the depth ROI obstacle detector.
package drod_pkg;

  localparam int unsigned CNT_W   = 21;
  localparam int unsigned SUM_W   = 31;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned ROI_W   = 11;
  localparam int unsigned FILL_W  = 17;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic [CNT_W-1:0]   COUNT_MAX       = '1;
  localparam logic [DEPTH_W:0]   FLOOR_MARGIN_MM = 17'd5;
  localparam logic [FILL_W-1:0]  Q16_ONE         = 17'd65536;
  localparam logic [OFF_W-1:0]   Q14_ONE         = 16'd16384;

  localparam logic [DEPTH_W-1:0] MIN_VALID_RST   = 16'd500;
  localparam logic [DEPTH_W-1:0] MAX_RANGE_RST   = 16'd2000;
  localparam logic [CNT_W-1:0]   MIN_PIXELS_RST  = 21'd80;
  localparam logic [DEPTH_W-1:0] NO_OBSTACLE_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROI_X_START,
    REG_ROI_X_END,
    REG_ROI_Y_START,
    REG_ROI_Y_END,
    REG_MIN_VALID_MM,
    REG_MAX_RANGE_MM,
    REG_MIN_PIXELS,
    REG_NO_OBSTACLE_MM
  } cfg_reg_e;

  typedef struct packed {
    logic [ROI_W-1:0]   roi_x_start;
    logic [ROI_W-1:0]   roi_x_end;
    logic [ROI_W-1:0]   roi_y_start;
    logic [ROI_W-1:0]   roi_y_end;
    logic [DEPTH_W-1:0] min_valid_mm;
    logic [DEPTH_W-1:0] max_range_mm;
    logic [CNT_W-1:0]   min_pixels;
    logic [DEPTH_W-1:0] no_obstacle_mm;
  } cfg_t;

  // Per-frame totals handed from the pixel front end to the result engine.
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [SUM_W-1:0]   sum;
    logic [DEPTH_W-1:0] nearest;
  } frame_acc_t;

endpackage

// ===== hw/rtl/drod_front.sv =====
// Pixel front end: configuration registers, pixel qualification and frame accumulation.
module drod_front #(
  parameter int unsigned X_W = 10,
  parameter int unsigned Y_W = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [drod_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [drod_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 fire_i,
  input  logic [drod_pkg::DEPTH_W-1:0]         depth_mm_i,
  input  logic [X_W-1:0]                       pix_x_i,
  input  logic [Y_W-1:0]                       pix_y_i,
  input  logic                                 frame_last_i,
  output logic                                 frame_push_o,
  output drod_pkg::frame_acc_t                 frame_o,
  output drod_pkg::cfg_t                       cfg_o
);

  localparam int unsigned CMP_W = ((X_W > Y_W) ? X_W : Y_W) + drod_pkg::ROI_W + 1;

  drod_pkg::cfg_t       cfg_q;
  drod_pkg::frame_acc_t acc_q, acc_d;
  logic                 in_roi, good, hit;
  logic [CMP_W-1:0]     px, py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roi_x_start    <= '0;
      cfg_q.roi_x_end      <= '0;
      cfg_q.roi_y_start    <= '0;
      cfg_q.roi_y_end      <= '0;
      cfg_q.min_valid_mm   <= drod_pkg::MIN_VALID_RST;
      cfg_q.max_range_mm   <= drod_pkg::MAX_RANGE_RST;
      cfg_q.min_pixels     <= drod_pkg::MIN_PIXELS_RST;
      cfg_q.no_obstacle_mm <= drod_pkg::NO_OBSTACLE_RST;
    end else if (cfg_we_i) begin
      unique case (drod_pkg::cfg_reg_e'(cfg_idx_i))
        drod_pkg::REG_ROI_X_START:    cfg_q.roi_x_start    <= cfg_data_i[drod_pkg::ROI_W-1:0];
        drod_pkg::REG_ROI_X_END:      cfg_q.roi_x_end      <= cfg_data_i[drod_pkg::ROI_W-1:0];
        drod_pkg::REG_ROI_Y_START:    cfg_q.roi_y_start    <= cfg_data_i[drod_pkg::ROI_W-1:0];
        drod_pkg::REG_ROI_Y_END:      cfg_q.roi_y_end      <= cfg_data_i[drod_pkg::ROI_W-1:0];
        drod_pkg::REG_MIN_VALID_MM:   cfg_q.min_valid_mm   <= cfg_data_i[drod_pkg::DEPTH_W-1:0];
        drod_pkg::REG_MAX_RANGE_MM:   cfg_q.max_range_mm   <= cfg_data_i[drod_pkg::DEPTH_W-1:0];
        drod_pkg::REG_MIN_PIXELS:     cfg_q.min_pixels     <= cfg_data_i[drod_pkg::CNT_W-1:0];
        drod_pkg::REG_NO_OBSTACLE_MM: cfg_q.no_obstacle_mm <= cfg_data_i[drod_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign px = CMP_W'(pix_x_i);
  assign py = CMP_W'(pix_y_i);

  assign in_roi = (px >= CMP_W'(cfg_q.roi_x_start)) && (px < CMP_W'(cfg_q.roi_x_end)) &&
                  (py >= CMP_W'(cfg_q.roi_y_start)) && (py < CMP_W'(cfg_q.roi_y_end));

  // Floor test runs one bit wider so min_valid + 5 cannot wrap.
  assign good = (depth_mm_i != '0) &&
                ({1'b0, depth_mm_i} > ({1'b0, cfg_q.min_valid_mm} + drod_pkg::FLOOR_MARGIN_MM)) &&
                (depth_mm_i <= cfg_q.max_range_mm);

  assign hit = in_roi && good;

  always_comb begin
    acc_d = acc_q;
    if (hit) begin
      // count saturates; column sum freezes with it
      if (acc_q.cnt != drod_pkg::COUNT_MAX) begin
        acc_d.cnt = acc_q.cnt + 1'b1;
        acc_d.sum = acc_q.sum + drod_pkg::SUM_W'(pix_x_i);
      end
      if (depth_mm_i < acc_q.nearest) begin
        acc_d.nearest = depth_mm_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q.cnt     <= '0;
      acc_q.sum     <= '0;
      acc_q.nearest <= '1;
    end else if (fire_i) begin
      if (frame_last_i) begin
        acc_q.cnt     <= '0;
        acc_q.sum     <= '0;
        acc_q.nearest <= '1;
      end else begin
        acc_q <= acc_d;
      end
    end
  end

  assign frame_push_o = fire_i && frame_last_i;
  assign frame_o      = acc_d;
  assign cfg_o        = cfg_q;

endmodule

// ===== hw/rtl/drod_fifo.sv =====
// Two-entry queue of frame totals between the front end and the result engine.
module drod_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  drod_pkg::frame_acc_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output drod_pkg::frame_acc_t rdata_o,
  output logic                 empty_o
);

  drod_pkg::frame_acc_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           fill_q;
  logic                 do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == '0);

endmodule

// ===== hw/rtl/drod_back.sv =====
// Result engine: per-frame multiplies, serial divisions and the result register.
`include "assert_macros.svh"

module drod_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drod_pkg::cfg_t                      cfg_i,
  input  logic                                fifo_empty_i,
  input  drod_pkg::frame_acc_t                fifo_data_i,
  output logic                                fifo_pop_o,
  input  logic                                res_pop_i,
  output logic                                res_valid_o,
  output logic                                obstacle_found_o,
  output logic [drod_pkg::DEPTH_W-1:0]        nearest_mm_o,
  output logic [drod_pkg::CNT_W-1:0]          point_count_o,
  output logic [drod_pkg::FILL_W-1:0]         fill_ratio_o,
  output logic signed [drod_pkg::OFF_W-1:0]   side_offset_o
);

  localparam int unsigned AREA_W    = 2 * drod_pkg::ROI_W;
  localparam int unsigned DEN_W     = drod_pkg::CNT_W + drod_pkg::ROI_W;
  localparam int unsigned CXS_W     = drod_pkg::CNT_W + drod_pkg::ROI_W + 1;
  localparam int unsigned NUM_W     = CXS_W + 2;
  localparam int unsigned FQ_W      = drod_pkg::FILL_W - 1;
  localparam int unsigned OQ_W      = drod_pkg::OFF_W - 2;
  localparam int unsigned STEP_W    = $clog2(FQ_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FQ_W - 1);
  localparam logic [STEP_W-1:0] OQ_STEPS  = STEP_W'(OQ_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                     state_q;
  drod_pkg::frame_acc_t       fr_acc_q;
  logic                       found_q, neg_q, fsat_q, osat_q;
  logic [AREA_W-1:0]          area_q, frem_q;
  logic [DEN_W-1:0]           den_q, orem_q;
  logic [CXS_W-1:0]           cxs_q;
  logic [FQ_W-1:0]            fq_q;
  logic [OQ_W-1:0]            oq_q;
  logic [STEP_W-1:0]          step_q;

  logic                       out_valid_q, out_found_q;
  logic [drod_pkg::DEPTH_W-1:0] out_near_q;
  logic [drod_pkg::CNT_W-1:0]   out_cnt_q;
  logic [drod_pkg::FILL_W-1:0]  out_fill_q;
  logic [drod_pkg::OFF_W-1:0]   out_side_q;

  // multiply stage
  logic [drod_pkg::ROI_W-1:0] w, h, dd;
  logic [drod_pkg::ROI_W:0]   xsum;
  // prepare stage
  logic [AREA_W-1:0]          area1;
  logic signed [NUM_W-1:0]    num;
  logic [NUM_W-1:0]           absn;
  // division step
  logic [AREA_W:0]            ft;
  logic                       fge;
  logic [DEN_W:0]             ot;
  logic                       oge;
  // result forming
  logic [OQ_W:0]              mag;
  logic [drod_pkg::OFF_W-1:0] side;
  logic                       fin_load;

  always_comb begin
    w    = (cfg_i.roi_x_end > cfg_i.roi_x_start) ? cfg_i.roi_x_end - cfg_i.roi_x_start : '0;
    h    = (cfg_i.roi_y_end > cfg_i.roi_y_start) ? cfg_i.roi_y_end - cfg_i.roi_y_start : '0;
    dd   = ({1'b0, cfg_i.roi_x_end} >= ({1'b0, cfg_i.roi_x_start} + 12'd2)) ? w
                                                                           : drod_pkg::ROI_W'(2);
    xsum = {1'b0, cfg_i.roi_x_start} + {1'b0, cfg_i.roi_x_end};

    area1 = (area_q == '0) ? AREA_W'(1) : area_q;
    num   = $signed({2'b00, fr_acc_q.sum, 1'b0}) - $signed({2'b00, cxs_q});
    absn  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    ft  = {frem_q, 1'b0};
    fge = (ft >= {1'b0, area_q});
    ot  = {orem_q, 1'b0};
    oge = (ot >= {1'b0, den_q});

    mag  = osat_q ? (OQ_W + 1)'(drod_pkg::Q14_ONE) : {1'b0, oq_q};
    side = (!found_q || (fr_acc_q.cnt == '0)) ? '0 :
           neg_q ? drod_pkg::OFF_W'(-drod_pkg::OFF_W'(mag)) : drod_pkg::OFF_W'(mag);

    fin_load = (state_q == ST_FIN) && (!out_valid_q || res_pop_i);
  end

  assign fifo_pop_o = (state_q == ST_IDLE) && !fifo_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fr_acc_q    <= '0;
      found_q     <= 1'b0;
      neg_q       <= 1'b0;
      fsat_q      <= 1'b0;
      osat_q      <= 1'b0;
      area_q      <= '0;
      frem_q      <= '0;
      den_q       <= '0;
      orem_q      <= '0;
      cxs_q       <= '0;
      fq_q        <= '0;
      oq_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_near_q  <= '0;
      out_cnt_q   <= '0;
      out_fill_q  <= '0;
      out_side_q  <= '0;
    end else begin
      // a transfer out in the same cycle as a new load keeps the register full
      if (out_valid_q && res_pop_i && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_empty_i) begin
            fr_acc_q <= fifo_data_i;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          area_q  <= AREA_W'(AREA_W'(w) * AREA_W'(h));
          den_q   <= DEN_W'(DEN_W'(fr_acc_q.cnt) * DEN_W'(dd));
          cxs_q   <= CXS_W'(CXS_W'(fr_acc_q.cnt) * CXS_W'(xsum));
          found_q <= (fr_acc_q.cnt >= cfg_i.min_pixels);
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          // ratio at or above one saturates, so the divided quotient is used only when it is fractional
          area_q  <= area1;
          fsat_q  <= ({1'b0, fr_acc_q.cnt} >= area1);
          frem_q  <= AREA_W'(fr_acc_q.cnt);
          neg_q   <= num[NUM_W-1];
          osat_q  <= (absn >= NUM_W'(den_q));
          orem_q  <= absn[DEN_W-1:0];
          fq_q    <= '0;
          oq_q    <= '0;
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          frem_q <= fge ? AREA_W'(ft - {1'b0, area_q}) : ft[AREA_W-1:0];
          fq_q   <= {fq_q[FQ_W-2:0], fge};
          if (step_q < OQ_STEPS) begin
            orem_q <= oge ? DEN_W'(ot - {1'b0, den_q}) : ot[DEN_W-1:0];
            oq_q   <= {oq_q[OQ_W-2:0], oge};
          end
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_valid_q <= 1'b1;
            out_found_q <= found_q;
            out_near_q  <= (fr_acc_q.cnt != '0) ? fr_acc_q.nearest : cfg_i.no_obstacle_mm;
            out_cnt_q   <= fr_acc_q.cnt;
            out_fill_q  <= fsat_q ? drod_pkg::Q16_ONE : {1'b0, fq_q};
            out_side_q  <= side;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o      = out_valid_q;
  assign obstacle_found_o = out_found_q;
  assign nearest_mm_o     = out_near_q;
  assign point_count_o    = out_cnt_q;
  assign fill_ratio_o     = out_fill_q;
  assign side_offset_o    = $signed(out_side_q);

  `ASSERT_CLK(a_side_zero_unless_found, clk_i, rst_ni, (out_valid_q && !out_found_q) |-> (out_side_q == '0))
  `ASSERT_CLK(a_near_default_when_empty, clk_i, rst_ni, (out_valid_q && (out_cnt_q == '0)) |-> (out_near_q == cfg_i.no_obstacle_mm))
  `ASSERT_CLK(a_div_ends_in_fin, clk_i, rst_ni, ((state_q == ST_DIV) && (step_q == LAST_STEP)) |=> (state_q == ST_FIN))
  `ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, fifo_pop_o && fifo_empty_i)

endmodule

// ===== hw/rtl/depth_roi_obstacle_detector_core.sv =====
// Top level of the depth ROI obstacle detector: front end, frame queue and result engine.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------------
//  pixels   | push / full         | depth_mm_i, pix_x_i, pix_y_i, frame_last_i
//  results  | pop / empty         | obstacle_found_o, nearest_mm_o, point_count_o,
//           |                     | fill_ratio_o, side_offset_o
//  config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One pixel per cycle while full is low; each pixel is judged and accumulated in the cycle
// it transfers. A frame's totals enter a two-entry queue, and the result engine works on one
// frame at a time (one fetch, one multiply, one prepare, 16 restoring-division steps, one
// result load). full rises only with two frames queued, i.e. when short frames pile up or
// results are not popped. Reset is asynchronous and clears all accumulators and queues.
module depth_roi_obstacle_detector_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [drod_pkg::DEPTH_W-1:0]        depth_mm_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        pix_x_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]       pix_y_i,
  input  logic                                frame_last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                obstacle_found_o,
  output logic [drod_pkg::DEPTH_W-1:0]        nearest_mm_o,
  output logic [drod_pkg::CNT_W-1:0]          point_count_o,
  output logic [drod_pkg::FILL_W-1:0]         fill_ratio_o,
  output logic signed [drod_pkg::OFF_W-1:0]   side_offset_o,
  input  logic                                cfg_we_i,
  input  logic [drod_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [drod_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned X_W = $clog2(MAX_WIDTH);
  localparam int unsigned Y_W = $clog2(MAX_HEIGHT);

  drod_pkg::cfg_t       cfg;
  drod_pkg::frame_acc_t frame_wr, frame_rd;
  logic                 fire, frame_push, q_full, q_empty, q_pop, res_valid;

  assign fire = push && !q_full;
  assign full = q_full;

  drod_front #(
    .X_W (X_W),
    .Y_W (Y_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .depth_mm_i   (depth_mm_i),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .frame_last_i (frame_last_i),
    .frame_push_o (frame_push),
    .frame_o      (frame_wr),
    .cfg_o        (cfg)
  );

  drod_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .wdata_i (frame_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (frame_rd),
    .empty_o (q_empty)
  );

  drod_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .fifo_empty_i     (q_empty),
    .fifo_data_i      (frame_rd),
    .fifo_pop_o       (q_pop),
    .res_pop_i        (pop),
    .res_valid_o      (res_valid),
    .obstacle_found_o (obstacle_found_o),
    .nearest_mm_o     (nearest_mm_o),
    .point_count_o    (point_count_o),
    .fill_ratio_o     (fill_ratio_o),
    .side_offset_o    (side_offset_o)
  );

  assign empty = !res_valid;

endmodule
